// File: hw/rtl/srks_pkg.sv
package srks_pkg;

  localparam int KEY_W             = 7;
  localparam int CNT_W             = 4;
  localparam int BYTE_W            = 8;
  localparam int BIT_W             = $clog2(BYTE_W);
  localparam int HELD_SLOTS        = 3;
  localparam int SLOT_W            = $clog2(HELD_SLOTS);
  localparam int MAX_KEYS          = 64;
  localparam int DEF_MAX_REGISTERS = 8;
  localparam int QUEUE_DEPTH       = 4;
  localparam int CFG_IDX_W         = 1;
  localparam int CFG_DATA_W        = 7;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LIMIT      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REGISTER_COUNT = 1'b1;

  localparam logic [KEY_W-1:0] KEY_LIMIT_RESET      = KEY_W'(64);
  localparam logic [CNT_W-1:0] REGISTER_COUNT_RESET = CNT_W'(1);

  typedef logic [KEY_W-1:0] key_t;

  // Pressed keys of one finished scan, already limited, ascending, zero meaning no key.
  typedef struct packed {
    key_t [HELD_SLOTS-1:0] keys;
    key_t                  limit;
  } scan_rec_t;

endpackage

// File: hw/rtl/srks_if.sv
interface srks_byte_if import srks_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
  modport mon    (input valid, input scan_byte, input ready);
endinterface

interface srks_event_if import srks_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_number;
  logic             is_press;
  logic             last_event;

  modport source (output valid, output key_number, output is_press, output last_event,
                  input ready);
  modport sink   (input valid, input key_number, input is_press, input last_event,
                  output ready);
  modport mon    (input valid, input key_number, input is_press, input last_event,
                  input ready);
endinterface

interface srks_cfg_if import srks_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
  modport mon    (input valid, input index, input data, input ready);
endinterface

// File: hw/rtl/srks_front.sv
module srks_front import srks_pkg::*; #(
  parameter int MAX_REGISTERS = DEF_MAX_REGISTERS
) (
  input  logic      clk,
  input  logic      rst,
  srks_byte_if.sink scan,
  srks_cfg_if.sink  cfg,
  input  logic      q_full,
  output logic      q_push,
  output scan_rec_t q_rec
);

  localparam int IDX_W = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;

  logic [KEY_W-1:0]      key_limit;
  logic [CNT_W-1:0]      register_count;
  logic [IDX_W-1:0]      byte_index;
  logic [1:0]            press_count;
  logic                  scan_stopped;
  key_t [HELD_SLOTS-1:0] held_keys;

  logic [1:0]            press_count_next;
  logic                  scan_stopped_next;
  key_t [HELD_SLOTS-1:0] held_keys_next;

  logic [CNT_W-1:0] eff_count;
  key_t             eff_limit;
  logic             at_last;
  logic             accept;

  always_comb begin
    if (register_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (register_count > CNT_W'(MAX_REGISTERS)) begin
      eff_count = CNT_W'(MAX_REGISTERS);
    end else begin
      eff_count = register_count;
    end
    if (key_limit == '0) begin
      eff_limit = KEY_W'(1);
    end else if (key_limit > KEY_W'(MAX_KEYS)) begin
      eff_limit = KEY_W'(MAX_KEYS);
    end else begin
      eff_limit = key_limit;
    end
  end

  assign at_last   = (CNT_W'(byte_index) + CNT_W'(1)) >= eff_count;
  assign scan.ready = !(q_full && at_last);
  assign cfg.ready  = 1'b1;
  assign accept     = scan.valid && scan.ready;
  assign q_push     = accept && at_last;

  // The first three pressed keys take slots; a fourth press stops the scan.
  always_comb begin
    press_count_next  = press_count;
    scan_stopped_next = scan_stopped;
    held_keys_next    = held_keys;
    for (int b = 0; b < BYTE_W; b++) begin
      if (!scan_stopped_next && !scan.scan_byte[b]) begin
        if (press_count_next < 2'(HELD_SLOTS)) begin
          held_keys_next[SLOT_W'(press_count_next)] =
            KEY_W'({byte_index, BIT_W'(b)}) + KEY_W'(1);
          press_count_next = press_count_next + 2'd1;
        end else begin
          scan_stopped_next = 1'b1;
        end
      end
    end
  end

  always_comb begin
    q_rec.limit = eff_limit;
    for (int i = 0; i < HELD_SLOTS; i++) begin
      if (held_keys_next[i] != '0 && held_keys_next[i] <= eff_limit) begin
        q_rec.keys[i] = held_keys_next[i];
      end else begin
        q_rec.keys[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_limit      <= KEY_LIMIT_RESET;
      register_count <= REGISTER_COUNT_RESET;
      byte_index     <= '0;
      press_count    <= '0;
      scan_stopped   <= 1'b0;
      held_keys      <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_KEY_LIMIT:      key_limit      <= KEY_W'(cfg.data);
          REG_REGISTER_COUNT: register_count <= cfg.data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (at_last) begin
          byte_index   <= '0;
          press_count  <= '0;
          scan_stopped <= 1'b0;
          held_keys    <= '0;
        end else begin
          byte_index   <= byte_index + IDX_W'(1);
          press_count  <= press_count_next;
          scan_stopped <= scan_stopped_next;
          held_keys    <= held_keys_next;
        end
      end
    end
  end

endmodule

// File: hw/rtl/srks_queue.sv
module srks_queue import srks_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  scan_rec_t rec_in,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output scan_rec_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  scan_rec_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = count == (PTR_W+1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= rec_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/srks_back.sv
module srks_back import srks_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_empty,
  input  scan_rec_t    q_head,
  output logic         q_pop,
  srks_event_if.source events
);

  key_t [HELD_SLOTS-1:0] down_keys;
  key_t [HELD_SLOTS-1:0] new_keys;
  key_t [HELD_SLOTS-1:0] old_keys;
  logic [HELD_SLOTS-1:0] new_mask;
  logic [HELD_SLOTS-1:0] old_mask;
  logic                  out_valid;
  key_t                  out_key;
  logic                  out_press;
  logic                  out_last;

  key_t [HELD_SLOTS-1:0] load_old;
  logic [HELD_SLOTS-1:0] load_new_mask;
  logic [HELD_SLOTS-1:0] load_old_mask;
  logic                  busy;
  logic                  load;
  logic                  fire;
  logic                  has_new;
  logic                  has_old;
  logic [SLOT_W-1:0]     new_sel;
  logic [SLOT_W-1:0]     old_sel;
  logic                  pick_new;

  assign busy  = |{new_mask, old_mask};
  assign load  = !busy && !q_empty;
  assign q_pop = load;
  assign fire  = busy && (!out_valid || events.ready);

  // Keys stored as down but above the new limit drop out silently.
  always_comb begin
    for (int j = 0; j < HELD_SLOTS; j++) begin
      load_old[j] = (down_keys[j] <= q_head.limit) ? down_keys[j] : '0;
    end
    for (int i = 0; i < HELD_SLOTS; i++) begin
      load_new_mask[i] = q_head.keys[i] != '0;
      load_old_mask[i] = load_old[i] != '0;
    end
    for (int i = 0; i < HELD_SLOTS; i++) begin
      for (int j = 0; j < HELD_SLOTS; j++) begin
        if (q_head.keys[i] != '0 && q_head.keys[i] == load_old[j]) begin
          load_new_mask[i] = 1'b0;
          load_old_mask[j] = 1'b0;
        end
      end
    end
  end

  // Both lists are ascending, so the lowest pending entry of each is a merge head.
  always_comb begin
    has_new = |new_mask;
    has_old = |old_mask;
    new_sel = '0;
    old_sel = '0;
    for (int i = HELD_SLOTS - 1; i >= 0; i--) begin
      if (new_mask[i]) begin
        new_sel = SLOT_W'(i);
      end
      if (old_mask[i]) begin
        old_sel = SLOT_W'(i);
      end
    end
    pick_new = has_new && (!has_old || new_keys[new_sel] < old_keys[old_sel]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down_keys <= '0;
      new_mask  <= '0;
      old_mask  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        down_keys <= q_head.keys;
        new_keys  <= q_head.keys;
        old_keys  <= load_old;
        new_mask  <= load_new_mask;
        old_mask  <= load_old_mask;
      end
      if (fire) begin
        out_valid <= 1'b1;
        out_last  <= $countones({new_mask, old_mask}) == 1;
        out_press <= pick_new;
        if (pick_new) begin
          out_key            <= new_keys[new_sel];
          new_mask[new_sel]  <= 1'b0;
        end else begin
          out_key            <= old_keys[old_sel];
          old_mask[old_sel]  <= 1'b0;
        end
      end else if (events.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign events.valid      = out_valid;
  assign events.key_number = out_key;
  assign events.is_press   = out_press;
  assign events.last_event = out_last;

endmodule

// File: hw/rtl/shift_register_key_scanner.sv
// Key scanner for a chain of parallel-in shift registers with three-key rollover. One byte
// of the chain is taken per transfer, one transfer per cycle, and register_count bytes
// (held to 1..MAX_REGISTERS) make a scan; a zero bit is a pressed key, numbered from 1
// upward starting at bit zero of the first byte. When the last byte of a scan is taken, its
// pressed keys go into a four-entry queue, and the event side then loads the scan and gives
// its press or release events one at a time (up to six, ascending key order, last_event set
// on the final one), while the byte side keeps taking bytes. The byte side stalls only on
// the last byte of a scan when the queue is full. Configuration writes are never stalled.
module shift_register_key_scanner import srks_pkg::*; #(
  parameter int MAX_REGISTERS = DEF_MAX_REGISTERS
) (
  input  logic         clk,
  input  logic         rst,
  srks_byte_if.sink    scan,
  srks_cfg_if.sink     cfg,
  srks_event_if.source events
);

  logic      q_full;
  logic      q_empty;
  logic      q_push;
  logic      q_pop;
  scan_rec_t q_rec;
  scan_rec_t q_head;

  srks_front #(
    .MAX_REGISTERS (MAX_REGISTERS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .scan   (scan),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_rec  (q_rec)
  );

  srks_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .rec_in (q_rec),
    .pop    (q_pop),
    .full   (q_full),
    .empty  (q_empty),
    .head   (q_head)
  );

  srks_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .events  (events)
  );

endmodule

// File: hw/rtl/srks_checker.sv
module srks_checker import srks_pkg::*; (
  input logic clk,
  input logic rst,
  input logic valid,
  input logic ready,
  input key_t key_number,
  input logic is_press,
  input logic last_event
);

  key_t prev_key;
  logic scan_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_open <= 1'b0;
    end else if (valid && ready) begin
      prev_key  <= key_number;
      scan_open <= !last_event;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !valid)
    else $error("Event offered right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=>
      valid && $stable(key_number) && $stable(is_press) && $stable(last_event))
    else $error("Stalled event changed.");

  a_key_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> key_number != '0 && key_number <= KEY_W'(MAX_KEYS))
    else $error("Event key number out of range.");

  a_ascending: assert property (@(posedge clk) disable iff (rst)
    valid && ready && scan_open |-> key_number > prev_key)
    else $error("Events of one scan are not in ascending key order.");

endmodule

bind shift_register_key_scanner srks_checker u_srks_checker (
  .clk        (clk),
  .rst        (rst),
  .valid      (events.valid),
  .ready      (events.ready),
  .key_number (events.key_number),
  .is_press   (events.is_press),
  .last_event (events.last_event)
);
